// ===== rtl/mca_pkg.sv =====
// Package for the monotonic clock with alarm: widths, reset values, request codes,
// register indexes and the command and status structs shared by controller and datapath.
// Depends on nothing.
package mca_pkg;

  localparam int CNT_W  = 32;
  localparam int NSPT_W = 30;
  localparam int TPS_W  = 32;
  localparam int Q_W    = 32;
  localparam int RCP_W  = Q_W + 1;
  localparam int PROD_W = NSPT_W + TPS_W;

  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [TPS_W-1:0] TPS_RESET = 32'd1000000;
  localparam logic [NSPT_W-1:0] NSPT_RESET = 30'd1000;
  localparam logic [TPS_W-1:0] CNT_MAX = TPS_W'((64'd1 << CNT_W) - 64'd1);
  localparam logic [RCP_W-1:0] NS_RECIP = RCP_W'((64'd1 << PROD_W) / NS_PER_SEC);

  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_MONO = 3'd1;
  localparam logic [2:0] REQ_REAL = 3'd2;
  localparam logic [2:0] REQ_SET  = 3'd3;
  localparam logic [2:0] REQ_DL   = 3'd4;

  localparam logic CFG_TPS  = 1'b0;
  localparam logic CFG_NSPT = 1'b1;

  typedef struct packed {
    logic cap;
    logic tick;
    logic mul;
    logic mono;
    logic act;
    logic chk;
    logic mulq;
    logic est;
    logic fix;
    logic load;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       reload;
    logic       act_chk;
    logic       chk_div;
  } sts_t;

  function automatic cnt_t cap_cnt(input logic [TPS_W-1:0] v);
    cnt_t r;
    r = (v > CNT_MAX) ? cnt_t'(CNT_MAX) : cnt_t'(v);
    return r;
  endfunction

endpackage

// ===== rtl/mca_ctrl.sv =====
// Controller of the monotonic clock with alarm: sequences each item through the datapath
// and owns the input and result handshakes. Depends on mca_pkg.
module mca_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_req_type,
  output logic             out_valid,
  input  logic             out_ready,
  input  mca_pkg::sts_t    sts,
  output mca_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TICK = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_MONO = 4'd3;
  localparam logic [3:0] ST_ACT  = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_MULQ = 4'd6;
  localparam logic [3:0] ST_EST  = 4'd7;
  localparam logic [3:0] ST_LOAD = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;
  localparam logic [3:0] ST_FIX  = 4'd10;

  logic [3:0]      state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          if (in_req_type == mca_pkg::REQ_TICK) begin
            state_nxt = ST_TICK;
          end else if (in_req_type <= mca_pkg::REQ_DL) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = sts.reload ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_MONO;
      end
      ST_MONO: begin
        cmd.mono  = 1'b1;
        state_nxt = (sts.req == mca_pkg::REQ_TICK) ? ST_CHK : ST_ACT;
      end
      ST_ACT: begin
        cmd.act   = 1'b1;
        state_nxt = sts.act_chk ? ST_CHK : ST_FIN;
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.chk_div ? ST_MULQ : ST_FIN;
      end
      ST_MULQ: begin
        cmd.mulq  = 1'b1;
        state_nxt = ST_EST;
      end
      ST_EST: begin
        cmd.est   = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/mca_dpath.sv =====
// Datapath of the monotonic clock with alarm: counters, time registers, the tick-time
// multiplier and the reciprocal divider for deadline scaling. Depends on mca_pkg.
module mca_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [2:0]          in_req_type,
  input  logic signed [63:0]  in_time_value,
  input  mca_pkg::cmd_t       cmd,
  output mca_pkg::sts_t       sts,
  output logic signed [63:0]  out_read_time,
  output logic                out_alarm_fired,
  output logic                out_second_elapsed
);

  localparam int PM_W = mca_pkg::CNT_W + mca_pkg::NSPT_W;
  localparam int PW   = mca_pkg::PROD_W;
  localparam int QW   = mca_pkg::Q_W;
  localparam int EM_W = mca_pkg::Q_W + mca_pkg::RCP_W;
  localparam int RM_W = mca_pkg::Q_W + 2;

  logic [mca_pkg::TPS_W-1:0]  tps_r;
  logic [mca_pkg::NSPT_W-1:0] nspt_r;
  logic [2:0]                 req_r;
  logic [63:0]                base_r;
  mca_pkg::cnt_t              period_r;
  mca_pkg::cnt_t              os_cnt_r;
  logic                       os_run_r;
  logic [63:0]                off_r;
  logic [63:0]                dl_r;
  logic                       dl_pend_r;
  logic                       alarm_w_r;
  logic                       sec_w_r;

  logic [63:0]                tv_r;
  logic [63:0]                prod_r;
  logic [63:0]                mono_r;
  logic [63:0]                rd_w_r;
  logic [mca_pkg::NSPT_W-1:0] dq_r;
  logic [PW-1:0]              num_r;
  logic [RM_W-1:0]            rem_r;
  logic [QW-1:0]              q_r;
  logic signed [63:0]         out_rd_r;
  logic                       out_alarm_r;
  logic                       out_sec_r;

  logic [PM_W-1:0] pm;
  logic [PW-1:0]   qm;
  logic [EM_W-1:0] em;
  logic [PW-1:0]   fm;
  logic [PW-1:0]   rm;
  logic [QW-1:0]   qf;
  logic [63:0]     diff;
  logic            dl_far;
  logic            tv_le;

  // The reciprocal estimate falls short of the true quotient by at most three.
  assign pm     = PM_W'(period_r) * PM_W'(nspt_r);
  assign qm     = PW'(dq_r) * PW'(tps_r);
  assign em     = EM_W'(num_r[PW-1:PW-QW]) * EM_W'(mca_pkg::NS_RECIP);
  assign fm     = PW'(q_r) * PW'(mca_pkg::NS_PER_SEC);
  assign rm     = num_r - fm;
  assign qf     = q_r + QW'(rem_r >= RM_W'(mca_pkg::NS_PER_SEC))
                      + QW'(rem_r >= RM_W'(64'd2 * mca_pkg::NS_PER_SEC))
                      + QW'(rem_r >= RM_W'(64'd3 * mca_pkg::NS_PER_SEC));
  assign diff   = dl_r - mono_r;
  assign dl_far = $signed(diff) > $signed(mca_pkg::NS_PER_SEC);
  assign tv_le  = $signed(tv_r) <= $signed(mono_r);

  assign sts.req     = req_r;
  assign sts.reload  = (period_r <= mca_pkg::cnt_t'(1));
  assign sts.act_chk = (req_r == mca_pkg::REQ_DL) && !tv_le;
  assign sts.chk_div = dl_pend_r && !dl_far && !diff[63];

  assign out_read_time      = out_rd_r;
  assign out_alarm_fired    = out_alarm_r;
  assign out_second_elapsed = out_sec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= mca_pkg::TPS_RESET;
      nspt_r    <= mca_pkg::NSPT_RESET;
      req_r     <= mca_pkg::REQ_TICK;
      base_r    <= mca_pkg::NS_PER_SEC;
      period_r  <= mca_pkg::cap_cnt(mca_pkg::TPS_RESET);
      os_cnt_r  <= '0;
      os_run_r  <= 1'b0;
      off_r     <= '0;
      dl_r      <= '0;
      dl_pend_r <= 1'b0;
      alarm_w_r <= 1'b0;
      sec_w_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mca_pkg::CFG_TPS:  tps_r  <= cfg_data;
          mca_pkg::CFG_NSPT: nspt_r <= cfg_data[mca_pkg::NSPT_W-1:0];
        endcase
      end
      if (cmd.cap) begin
        req_r     <= in_req_type;
        alarm_w_r <= 1'b0;
        sec_w_r   <= 1'b0;
      end
      if (cmd.tick) begin
        if (os_run_r) begin
          if (os_cnt_r <= mca_pkg::cnt_t'(1)) begin
            os_cnt_r  <= '0;
            os_run_r  <= 1'b0;
            alarm_w_r <= 1'b1;
          end else begin
            os_cnt_r <= os_cnt_r - mca_pkg::cnt_t'(1);
          end
        end
        if (sts.reload) begin
          period_r <= mca_pkg::cap_cnt(tps_r);
          base_r   <= base_r + mca_pkg::NS_PER_SEC;
          sec_w_r  <= 1'b1;
        end else begin
          period_r <= period_r - mca_pkg::cnt_t'(1);
        end
      end
      if (cmd.act) begin
        if (req_r == mca_pkg::REQ_SET) begin
          off_r <= tv_r - mono_r;
        end else if (req_r == mca_pkg::REQ_DL) begin
          if (tv_le) begin
            dl_pend_r <= 1'b0;
            alarm_w_r <= 1'b1;
          end else begin
            dl_pend_r <= 1'b1;
            dl_r      <= tv_r;
          end
        end
      end
      if (cmd.chk && dl_pend_r && !dl_far) begin
        dl_pend_r <= 1'b0;
        if (diff[63]) begin
          os_cnt_r <= '0;
          os_run_r <= 1'b1;
        end
      end
      if (cmd.load) begin
        os_cnt_r <= mca_pkg::cap_cnt(qf);
        os_run_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      tv_r   <= in_time_value;
      rd_w_r <= '0;
    end
    if (cmd.mul) begin
      prod_r <= 64'(pm);
    end
    if (cmd.mono) begin
      mono_r <= base_r - prod_r;
    end
    if (cmd.act) begin
      if (req_r == mca_pkg::REQ_MONO) begin
        rd_w_r <= mono_r;
      end else if (req_r == mca_pkg::REQ_REAL) begin
        rd_w_r <= mono_r + off_r;
      end
    end
    if (cmd.chk) begin
      dq_r <= diff[mca_pkg::NSPT_W-1:0];
    end
    if (cmd.mulq) begin
      num_r <= qm;
    end
    if (cmd.est) begin
      q_r <= em[EM_W-2:QW];
    end
    if (cmd.fix) begin
      rem_r <= rm[RM_W-1:0];
    end
    if (cmd.fin) begin
      out_rd_r    <= $signed(rd_w_r);
      out_alarm_r <= alarm_w_r;
      out_sec_r   <= sec_w_r;
    end
  end

endmodule

// ===== rtl/monotonic_clock_with_alarm.sv =====
// Top level of the monotonic clock with alarm: joins the controller and the datapath.
// Depends on mca_pkg, mca_ctrl and mca_dpath.

// Works on one item at a time. A tick passes the tick state, plus the product, sum and
// check states when the periodic counter reloads and the pending deadline is rechecked;
// a time read or set passes the product, sum and action states, and a deadline start
// also the check state, since the tick-time product and the monotonic sum are each
// registered. When a deadline comes within one second, its scaling to ticks runs through
// a reciprocal multiplication, a remainder step and a final correction. An item also
// waits in its final state while the previous result has not been collected. The next
// item is taken as soon as the result is in the output register, even if that result
// has not yet been collected. Configuration writes are always accepted and should be made while idle.
module monotonic_clock_with_alarm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [63:0] in_time_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_read_time,
  output logic               out_alarm_fired,
  output logic               out_second_elapsed
);

  mca_pkg::cmd_t cmd;
  mca_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  mca_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  mca_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_req_type        (in_req_type),
    .in_time_value      (in_time_value),
    .cmd                (cmd),
    .sts                (sts),
    .out_read_time      (out_read_time),
    .out_alarm_fired    (out_alarm_fired),
    .out_second_elapsed (out_second_elapsed)
  );

endmodule

// ===== rtl/mca_checker.sv =====
// Port-level checker for the monotonic clock with alarm, bound to the top level.
// Depends on monotonic_clock_with_alarm.
module mca_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] out_read_time,
  input logic               out_alarm_fired,
  input logic               out_second_elapsed
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_time) &&
      $stable(out_alarm_fired) && $stable(out_second_elapsed))
    else $error("result changed while stalled");

  // Reset leaves no result on the port.
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Each item is processed alone, so the input closes for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // A second boundary comes only from a tick, which returns no time.
  a_sec_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_elapsed |-> out_read_time == 64'sd0)
    else $error("time returned with a second boundary");

endmodule

bind monotonic_clock_with_alarm mca_checker u_mca_checker (.*);

// ===== test/mca_time_checker.sv =====
`timescale 1ns / 100ps
// Checker for the monotonic clock with alarm: watches the register, request and reply
// channels, keeps its own copy of the clock state and compares every reply in order.
// Depends on mca_pkg for the request codes and the register indexes.
module mca_time_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [63:0] in_time_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_read_time,
  input  logic        out_alarm_fired,
  input  logic        out_second_elapsed,
  output int          fail_total,
  output int          replies_owed,
  output logic [63:0] mono_now
);
  import mca_pkg::*;

  localparam logic [63:0] ONE_SEC_NS    = 64'd1_000_000_000;
  localparam logic [63:0] SHOT_MAX      = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] TPS_AT_RESET  = 32'd1_000_000;
  localparam logic [29:0] NSPT_AT_RESET = 30'd1000;

  typedef struct packed {
    logic [63:0] read_time;
    logic        alarm_fired;
    logic        second_elapsed;
  } clock_reply_t;

  logic [31:0]  tps;
  logic [29:0]  nspt;
  logic [63:0]  seconds;
  logic [31:0]  period_left;
  logic [31:0]  shot_left;
  logic         shot_armed;
  logic [63:0]  rt_offset;
  logic [63:0]  deadline;
  logic         deadline_held;
  clock_reply_t pending_replies[$];
  int           err_count = 0;

  function automatic logic [63:0] clock_ns();
    return seconds * ONE_SEC_NS + ONE_SEC_NS - {32'd0, period_left} * {34'd0, nspt};
  endfunction

  // A held deadline moves into the one-shot counter once it is no more than a second away.
  task automatic rearm_alarm();
    logic signed [63:0] gap;
    logic [63:0]        ticks_to_go;
    if (deadline_held) begin
      gap = deadline - clock_ns();
      if (gap <= $signed(ONE_SEC_NS)) begin
        deadline_held = 1'b0;
        ticks_to_go = (gap < 0) ? 64'd0 : ($unsigned(gap) * {32'd0, tps}) / ONE_SEC_NS;
        shot_left = (ticks_to_go > SHOT_MAX) ? 32'hFFFF_FFFF : ticks_to_go[31:0];
        shot_armed = 1'b1;
      end
    end
  endtask

  task automatic advance_clock(input logic [2:0] req, input logic [63:0] tv,
                               output clock_reply_t reply);
    reply = '0;
    case (req)
      REQ_TICK: begin
        if (shot_armed) begin
          if (shot_left <= 32'd1) begin
            shot_left = '0;
            shot_armed = 1'b0;
            reply.alarm_fired = 1'b1;
          end else begin
            shot_left = shot_left - 32'd1;
          end
        end
        if (period_left <= 32'd1) begin
          period_left = tps;
          seconds = seconds + 64'd1;
          reply.second_elapsed = 1'b1;
          rearm_alarm();
        end else begin
          period_left = period_left - 32'd1;
        end
      end
      REQ_MONO: reply.read_time = clock_ns();
      REQ_REAL: reply.read_time = clock_ns() + rt_offset;
      REQ_SET:  rt_offset = tv - clock_ns();
      REQ_DL: begin
        if ($signed(tv) <= $signed(clock_ns())) begin
          deadline_held = 1'b0;
          reply.alarm_fired = 1'b1;
        end else begin
          deadline_held = 1'b1;
          deadline = tv;
          rearm_alarm();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    clock_reply_t want;
    if (!rst_n) begin
      tps = TPS_AT_RESET;
      nspt = NSPT_AT_RESET;
      seconds = '0;
      period_left = TPS_AT_RESET;
      shot_left = '0;
      shot_armed = 1'b0;
      rt_offset = '0;
      deadline = '0;
      deadline_held = 1'b0;
      pending_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TPS) begin
          tps = cfg_data;
        end else begin
          nspt = cfg_data[29:0];
        end
      end
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $error("reply seen with no request waiting for it");
          err_count++;
        end else begin
          want = pending_replies.pop_front();
          if (out_read_time !== want.read_time) begin
            $error("read_time: expected %0d, got %0d", $signed(want.read_time),
                   $signed(out_read_time));
            err_count++;
          end
          if (out_alarm_fired !== want.alarm_fired) begin
            $error("alarm_fired: expected %0b, got %0b", want.alarm_fired, out_alarm_fired);
            err_count++;
          end
          if (out_second_elapsed !== want.second_elapsed) begin
            $error("second_elapsed: expected %0b, got %0b", want.second_elapsed,
                   out_second_elapsed);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_clock(in_req_type, in_time_value, want);
        pending_replies.push_back(want);
      end
    end
    fail_total <= err_count;
    replies_owed <= pending_replies.size();
    mono_now <= clock_ns();
  end

endmodule

// ===== test/monotonic_clock_with_alarm_tb.sv =====
`timescale 1ns / 100ps
// Top of the monotonic clock with alarm testbench: clock, reset, request and register
// traffic, reply back-pressure and the verdict. Depends on mca_pkg, the block itself and
// mca_time_checker, which does all prediction and comparison.
module monotonic_clock_with_alarm_tb;
  import mca_pkg::*;

  localparam logic [2:0]  REQ_SPARE_A      = 3'd5;
  localparam logic [63:0] ONE_SEC_NS       = 64'd1_000_000_000;
  localparam logic [63:0] MOST_POSITIVE    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEGATIVE    = 64'h8000_0000_0000_0000;
  localparam int          RANDOM_PER_PHASE = 190;
  localparam int          LONG_STALL       = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_TPS;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_req_type = REQ_TICK;
  logic signed [63:0] in_time_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] out_read_time;
  logic               out_alarm_fired;
  logic               out_second_elapsed;
  int                 fail_total;
  int                 replies_owed;
  logic [63:0]        mono_now;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 stall_asked = 0;
  int                 stall_served = 0;
  int                 stall_left = 0;

  monotonic_clock_with_alarm dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_time_value      (in_time_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_time      (out_read_time),
    .out_alarm_fired    (out_alarm_fired),
    .out_second_elapsed (out_second_elapsed)
  );

  mca_time_checker u_time_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_time_value      (in_time_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_time      (out_read_time),
    .out_alarm_fired    (out_alarm_fired),
    .out_second_elapsed (out_second_elapsed),
    .fail_total         (fail_total),
    .replies_owed       (replies_owed),
    .mono_now           (mono_now)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_served != stall_asked) begin
      stall_served = stall_asked;
      stall_left = LONG_STALL;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic offer(input logic [2:0] req, input logic [63:0] tv);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_time_value <= tv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  task automatic program_clock(input logic [31:0] tps_word, input logic [31:0] nspt_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TPS;
    cfg_data <= tps_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_NSPT;
    cfg_data <= nspt_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Deadlines are mostly placed near the current time so that they land in the past, load
  // the one-shot counter at once, or wait a few seconds for a reload to pick them up.
  task automatic random_request();
    int unsigned pick;
    logic [63:0] tv;
    logic [2:0]  req;
    pick = $urandom_range(0, 99);
    tv = {$urandom, $urandom};
    if (pick < 44) begin
      req = REQ_TICK;
    end else if (pick < 52) begin
      req = REQ_MONO;
    end else if (pick < 60) begin
      req = REQ_REAL;
    end else if (pick < 67) begin
      req = REQ_SET;
      if (pick < 64) tv = mono_now + 64'($urandom);
    end else if (pick < 94) begin
      req = REQ_DL;
      if (pick < 91) begin
        tv = mono_now + 64'($urandom_range(0, 32'd3_500_000_000)) - 64'd500_000_000;
      end
    end else begin
      req = REQ_SPARE_A + 3'($urandom_range(0, 2));
    end
    offer(req, tv);
  endtask

  task automatic run_phase(input logic [31:0] tps_word, input logic [31:0] nspt_word,
                           input int sender_pct, input int receiver_pct, input bit with_stall);
    settle();
    program_clock(tps_word, nspt_word);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      if (with_stall && n == 40) stall_asked <= stall_asked + 1;
      random_request();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 18;
    recv_idle_pct <= 58;

    offer(REQ_MONO, '0);
    offer(REQ_REAL, '0);
    offer(REQ_SET, MOST_POSITIVE);
    offer(REQ_REAL, '0);
    offer(REQ_SET, MOST_NEGATIVE);
    offer(REQ_REAL, '0);
    offer(REQ_SET, '0);
    offer(REQ_TICK, '1);
    offer(REQ_MONO, '1);
    offer(REQ_DL, MOST_NEGATIVE);
    settle();
    offer(REQ_DL, mono_now);
    offer(REQ_DL, mono_now + 64'd1);
    offer(REQ_TICK, '0);
    settle();
    offer(REQ_DL, mono_now + ONE_SEC_NS);
    offer(REQ_DL, mono_now + 64'd2000);
    offer(REQ_TICK, '0);
    offer(REQ_TICK, '0);
    offer(REQ_DL, MOST_POSITIVE);
    offer(REQ_DL, '1);
    offer(REQ_SPARE_A, '1);
    offer(REQ_SPARE_A + 3'd1, MOST_NEGATIVE);
    offer(REQ_SPARE_A + 3'd2, 64'h5555_5555_AAAA_AAAA);
    settle();
    offer(REQ_DL, mono_now + ONE_SEC_NS + 64'd1);
    offer(REQ_REAL, '0);

    run_phase(32'd1, 32'd1_000_000_000, 18, 58, 1'b1);
    run_phase(32'd0, 32'd7, 18, 58, 1'b0);
    run_phase(32'd5, 32'hFFFF_FFFF, 58, 18, 1'b1);
    run_phase(32'($urandom_range(2, 16)), $urandom, 58, 18, 1'b0);
    run_phase(32'd7, 32'd142_857_143, 0, 0, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'd1, 0, 0, 1'b0);
    settle();
    repeat (60) @(posedge clk);
    if (fail_total == 0 && replies_owed == 0) begin
      $display("[monotonic_clock_with_alarm] OK");
    end else begin
      $display("[monotonic_clock_with_alarm] ERROR");
    end
    $finish;
  end

  initial begin
    #120_000_000;
    $display("[monotonic_clock_with_alarm] ERROR");
    $finish;
  end

endmodule
